// ===== hdl/pthfk_pkg.sv =====
// Package for the pan-tilt head forward kinematics block.
// Holds CORDIC and kinematic constants, the arctangent table and shared types; no dependencies.
package pthfk_pkg;

    localparam int CordicIters = 16;
    localparam int AngW        = 16;
    localparam int ZW          = 32;
    localparam int XyW         = 34;
    localparam int RotW        = 16;
    localparam int TransW      = 18;

    localparam logic signed [ZW-1:0]  PiQ28     = 32'sd843314857;
    localparam logic signed [ZW-1:0]  HalfPiQ28 = 32'sd421657428;
    localparam logic signed [XyW-1:0] GainQ30   = 34'sd652032874;

    localparam logic signed [RotW-1:0] RotMax = 16'sd16384;
    localparam logic signed [RotW-1:0] RotMin = -16'sd16384;

    localparam logic signed [15:0] K028 = 16'sd1835;
    localparam logic signed [15:0] K030 = 16'sd1966;
    localparam logic signed [15:0] K052 = 16'sd3408;
    localparam logic signed [TransW-1:0] OffX = -18'sd4915;
    localparam logic signed [TransW-1:0] OffZ = 18'sd24576;
    localparam logic signed [TransW-1:0] TransMax = 18'sd65536;
    localparam logic signed [TransW-1:0] TransMin = -18'sd65536;

    typedef logic signed [ZW-1:0]  z_t;
    typedef logic signed [XyW-1:0] xy_t;

    // One angle in flight through a CORDIC cell.
    typedef struct packed {
        xy_t  x;
        xy_t  y;
        z_t   z;
        logic neg;
    } cord_t;

    function automatic z_t atan_q28(input logic [3:0] i);
        case (i)
            4'd0:    return 32'sd210828714;
            4'd1:    return 32'sd124459457;
            4'd2:    return 32'sd65760959;
            4'd3:    return 32'sd33381290;
            4'd4:    return 32'sd16755422;
            4'd5:    return 32'sd8385879;
            4'd6:    return 32'sd4193963;
            4'd7:    return 32'sd2097109;
            4'd8:    return 32'sd1048571;
            4'd9:    return 32'sd524287;
            4'd10:   return 32'sd262144;
            4'd11:   return 32'sd131072;
            4'd12:   return 32'sd65536;
            4'd13:   return 32'sd32768;
            4'd14:   return 32'sd16384;
            default: return 32'sd8192;
        endcase
    endfunction

endpackage

// ===== hdl/pthfk_cordic_cell.sv =====
// One CORDIC micro-rotation cell with its own stage register.
// Depends on pthfk_pkg.
module pthfk_cordic_cell
    import pthfk_pkg::*;
#(
    parameter int Stage = 0
)
(
    input  logic  clk,
    input  logic  en,
    input  cord_t a_in,
    input  cord_t b_in,
    output cord_t a_out,
    output cord_t b_out
);

    localparam z_t Atan = atan_q28(4'(Stage));

    function automatic cord_t rot(input cord_t c);
        cord_t r;
        xy_t   dx;
        xy_t   dy;
        r  = c;
        dx = c.y >>> Stage;
        dy = c.x >>> Stage;
        if (!c.z[ZW-1])
        begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.z = c.z - Atan;
        end
        else
        begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.z = c.z + Atan;
        end
        return r;
    endfunction

    cord_t a_reg, b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= rot(a_in);
            b_reg <= rot(b_in);
        end
    end

    assign a_out = a_reg;
    assign b_out = b_reg;

endmodule

// ===== hdl/pthfk_pose.sv =====
// Pose back end: rounds sine/cosine, forms rotation products and translations.
// Depends on pthfk_pkg; two register stages, all enabled by the pipeline advance.
module pthfk_pose
    import pthfk_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  cord_t pan_in,
    input  cord_t tilt_in,
    output logic [199:0] pose
);

    typedef logic signed [RotW-1:0] r_t;

    function automatic r_t sc_round(input xy_t v, input logic neg);
        logic signed [XyW:0] t;
        logic signed [XyW:0] q;
        t = neg ? -{v[XyW-1], v} : {v[XyW-1], v};
        q = (t + 35'sd32768) >>> 16;
        if (q > 35'(RotMax)) return RotMax;
        if (q < 35'(RotMin)) return RotMin;
        return RotW'(q);
    endfunction

    function automatic r_t p_round(input logic signed [31:0] p);
        logic signed [31:0] q;
        q = (p + 32'sd8192) >>> 14;
        if (q > 32'(RotMax)) return RotMax;
        if (q < 32'(RotMin)) return RotMin;
        return RotW'(q);
    endfunction

    function automatic logic signed [TransW-1:0] t_round(
        input logic signed [TransW-1:0] off, input logic signed [47:0] s);
        logic signed [47:0] q;
        q = ((s + 48'sd134217728) >>> 28) + 48'(off);
        if (q > 48'(TransMax)) return TransMax;
        if (q < 48'(TransMin)) return TransMin;
        return TransW'(q);
    endfunction

    // Stage 1: rounded sine/cosine and the four angle products.
    r_t s1_reg, c1_reg, s2_reg, c2_reg;
    logic signed [31:0] c1c2_reg, c1s2_reg, s1c2_reg, s1s2_reg;
    r_t s1, c1, s2, c2;

    always_comb
    begin
        s1 = sc_round(pan_in.y, pan_in.neg);
        c1 = sc_round(pan_in.x, pan_in.neg);
        s2 = sc_round(tilt_in.y, tilt_in.neg);
        c2 = sc_round(tilt_in.x, tilt_in.neg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= s1;
            c1_reg   <= c1;
            s2_reg   <= s2;
            c2_reg   <= c2;
            c1c2_reg <= 32'(c1) * 32'(c2);
            c1s2_reg <= 32'(c1) * 32'(s2);
            s1c2_reg <= 32'(s1) * 32'(c2);
            s1s2_reg <= 32'(s1) * 32'(s2);
        end
    end

    // Stage 2: rounding and the translation sums with constant coefficients.
    logic signed [47:0] sx, sy, sz;
    logic [199:0] pose_next, pose_reg;

    always_comb
    begin
        sx = 48'(K028) * 48'(c1c2_reg) + 48'(K052) * 48'(c1s2_reg)
           - 48'(K030) * 48'(s1_reg) * 48'sd16384;
        sy = 48'(K028) * 48'(s1c2_reg) + 48'(K052) * 48'(s1s2_reg)
           + 48'(K030) * 48'(c1_reg) * 48'sd16384;
        sz = 48'sd16384 * (48'(K052) * 48'(c2_reg) - 48'(K028) * 48'(s2_reg));
        pose_next = {
            2'd0,
            t_round(OffZ, sz),
            t_round(18'sd0, sy),
            t_round(OffX, sx),
            -s2_reg,
            -c2_reg,
            r_t'(0),
            p_round(s1c2_reg),
            p_round(-s1s2_reg),
            -c1_reg,
            p_round(c1c2_reg),
            p_round(-c1s2_reg),
            s1_reg
        };
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pose_reg <= pose_next;
        end
    end

    assign pose = pose_reg;

endmodule

// ===== hdl/pan_tilt_head_forward_kinematics.sv =====
// Top level of the pan-tilt head forward kinematics block.
// Depends on pthfk_pkg, pthfk_cordic_cell and pthfk_pose.
//
// Usage:
//   The slave channel (s_axis_*) carries one beat per joint pair: pan_angle
//   in tdata[15:0] and tilt_angle in tdata[31:16], both signed Q3.13 radians.
//   The master channel (m_axis_*) returns one beat per input beat holding
//   the nine Q1.14 rotation elements followed by three 18-bit translations
//   in 1/65536 m, packed without gaps and topped up with two zero bits.
//   Sine and cosine come from a row of 16 CORDIC cells, one
//   micro-rotation per cell; pan and tilt travel side by side through it.
//   The pipe is a pre-rotation register, 16 cells, a product stage and
//   the output register. Throughput is one beat per cycle while not stalled.
//   The whole pipe advances together whenever the output register is empty
//   or being drained, so a receiver stall freezes every stage and s_axis_tready
//   falls; nothing is lost or duplicated. A valid bit per stage is reset by
//   rst_n (asynchronous, active low); the data registers are not reset.
module pan_tilt_head_forward_kinematics
    import pthfk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // pan_angle, tilt_angle
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rot_r0_c0..rot_r2_c2 (16 b each), trans_x, trans_y, trans_z (18 b each), 2'b0
    output logic [199:0] m_axis_tdata
);

    localparam int Depth = CordicIters + 3;

    logic en;
    logic [Depth-1:0] vld_reg;
    logic [Depth-1:0] vld_next;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[Depth-1];

    always_comb
    begin
        vld_next = {vld_reg[Depth-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Quadrant fold into [-pi/2, pi/2] at Q.28.
    function automatic cord_t pre(input logic signed [AngW-1:0] a);
        cord_t c;
        z_t    z;
        z     = z_t'(a) <<< 15;
        c.x   = GainQ30;
        c.y   = '0;
        c.neg = 1'b0;
        c.z   = z;
        if (z > HalfPiQ28)
        begin
            c.z   = z - PiQ28;
            c.neg = 1'b1;
        end
        else if (z < -HalfPiQ28)
        begin
            c.z   = z + PiQ28;
            c.neg = 1'b1;
        end
        return c;
    endfunction

    cord_t pan_chain [CordicIters+1];
    cord_t tilt_chain [CordicIters+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pan_chain[0]  <= pre(s_axis_tdata[15:0]);
            tilt_chain[0] <= pre(s_axis_tdata[31:16]);
        end
    end

    for (genvar g = 0; g < CordicIters; g++)
    begin : g_cell
        pthfk_cordic_cell #(.Stage(g)) u_cell (
            .clk   (clk),
            .en    (en),
            .a_in  (pan_chain[g]),
            .b_in  (tilt_chain[g]),
            .a_out (pan_chain[g+1]),
            .b_out (tilt_chain[g+1])
        );
    end

    pthfk_pose u_pose (
        .clk     (clk),
        .en      (en),
        .pan_in  (pan_chain[CordicIters]),
        .tilt_in (tilt_chain[CordicIters]),
        .pose    (m_axis_tdata)
    );

endmodule

// ===== sim/pthfk_checker.sv =====
// Checker for the pan-tilt head forward kinematics block: watches both stream
// channels, predicts each pose from the accepted angle pair and compares.
// Depends on pthfk_pkg for widths.
`timescale 1ns / 100ps

module pthfk_checker
    import pthfk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [199:0] m_axis_tdata,
    output int           fail_count,
    output int           poses_pending
);

    typedef struct {
        logic signed [RotW-1:0]   rot [9];
        logic signed [TransW-1:0] trans [3];
    } pose_t;

    pose_t pose_q[$];

    localparam longint ArcTab [16] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
        2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192};

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Arithmetic shift of a longint rounds toward minus infinity.
    function automatic void trig_of(input logic signed [15:0] ang,
                                    output longint sn, output longint cs);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) * 32768;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 421657428)
        begin
            z -= 843314857;
            flip = 1;
        end
        else if (z < -421657428)
        begin
            z += 843314857;
            flip = 1;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ArcTab[i];
            end
            else
            begin
                x += dx; y -= dy; z += ArcTab[i];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        cs = clip((x + 32768) >>> 16, -16384, 16384);
        sn = clip((y + 32768) >>> 16, -16384, 16384);
    endfunction

    function automatic longint rot_of(longint p);
        return clip((p + 8192) >>> 14, -16384, 16384);
    endfunction

    function automatic longint trans_of(longint off, longint sum);
        return clip(off + ((sum + (64'sd1 <<< 27)) >>> 28), -65536, 65536);
    endfunction

    function automatic pose_t head_pose(logic [31:0] angles);
        pose_t p;
        longint s1, c1, s2, c2;
        trig_of(angles[15:0], s1, c1);
        trig_of(angles[31:16], s2, c2);
        p.rot[0] = RotW'(s1);
        p.rot[1] = RotW'(rot_of(-c1 * s2));
        p.rot[2] = RotW'(rot_of(c1 * c2));
        p.rot[3] = RotW'(-c1);
        p.rot[4] = RotW'(rot_of(-s1 * s2));
        p.rot[5] = RotW'(rot_of(s1 * c2));
        p.rot[6] = '0;
        p.rot[7] = RotW'(-c2);
        p.rot[8] = RotW'(-s2);
        p.trans[0] = TransW'(trans_of(-4915,
                                      1835 * c1 * c2 + 3408 * c1 * s2 - 1966 * s1 * 16384));
        p.trans[1] = TransW'(trans_of(0,
                                      1835 * s1 * c2 + 3408 * s1 * s2 + 1966 * c1 * 16384));
        p.trans[2] = TransW'(trans_of(24576, -1835 * s2 * 16384 + 3408 * c2 * 16384));
        return p;
    endfunction

    assign poses_pending = pose_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        pose_t want;
        logic [15:0] got_r;
        logic [17:0] got_t;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                pose_q.insert(pose_q.size(), head_pose(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pose_q.size() == 0)
                begin
                    $display("%0t: unexpected pose beat, expected none, actual %h",
                             $time, m_axis_tdata);
                    errs++;
                end
                else
                begin
                    want = pose_q.pop_front();
                    for (int k = 0; k < 9; k++)
                    begin
                        got_r = m_axis_tdata[16*k +: 16];
                        if (got_r !== want.rot[k])
                        begin
                            $display("%0t: rotation element %0d expected %0d actual %0d",
                                     $time, k, want.rot[k], $signed(got_r));
                            errs++;
                        end
                    end
                    for (int k = 0; k < 3; k++)
                    begin
                        got_t = m_axis_tdata[144 + 18*k +: 18];
                        if (got_t !== want.trans[k])
                        begin
                            $display("%0t: translation %0d expected %0d actual %0d",
                                     $time, k, want.trans[k], $signed(got_t));
                            errs++;
                        end
                    end
                    if (m_axis_tdata[199:198] !== 2'b0)
                    begin
                        $display("%0t: pad bits expected %b actual %b",
                                 $time, 2'b0, m_axis_tdata[199:198]);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

// ===== sim/tb_pan_tilt_head_forward_kinematics.sv =====
// Testbench top for the pan-tilt head forward kinematics block: drives angle
// pairs with random gaps and receiver stalls; pthfk_checker does the checking.
`timescale 1ns / 100ps

module tb_pan_tilt_head_forward_kinematics;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;
    int           fail_count;
    int           poses_pending;

    pan_tilt_head_forward_kinematics u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pthfk_checker u_checker (.*);

    initial
    begin
        clk = 0;
    end

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver side: random stalls, with stretches of constant readiness.
    initial
    begin
        int n;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 30);
            repeat (n) @(posedge clk) m_axis_tready <= 1'b1;
            n = gap_len();
            repeat (n) @(posedge clk) m_axis_tready <= 1'b0;
        end
    end

    // Sends one angle pair; returns at the edge where it is accepted, or after
    // the idle gap that follows it. Valid stays high when the next beat
    // follows with no gap.
    task automatic send_pair(logic [15:0] pan, logic [15:0] tilt, int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tilt, pan};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mostly the stated range; the rest any 16-bit pattern.
    function automatic logic [15:0] rand_angle();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 51472) - 25736);
    endfunction

    localparam logic [15:0] DirAngles [12] = '{
        16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868, 16'sd12869,
        -16'sd12869, 16'sd6434, 16'h7fff, 16'h8000, 16'hffff, 16'sd1};

    initial
    begin
        rst_n         = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: range ends, quadrant edges, and out-of-range patterns.
        for (int i = 0; i < 12; i++)
            send_pair(DirAngles[i], DirAngles[11 - i], gap_len());
        for (int i = 0; i < 12; i++)
            send_pair(DirAngles[(i * 5) % 12], DirAngles[i], 0);

        // Hold off until the pipe has fully drained.
        s_axis_tvalid <= 1'b0;
        while (poses_pending != 0)
            @(posedge clk);

        for (int i = 0; i < 1800; i++)
        begin
            send_pair(rand_angle(), rand_angle(), (i % 300 < 60) ? 0 : gap_len());
        end
        s_axis_tvalid <= 1'b0;

        while (poses_pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb_pan_tilt_head_forward_kinematics: PASS");
        else
            $display("tb_pan_tilt_head_forward_kinematics: FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_pan_tilt_head_forward_kinematics: FAIL");
        $finish;
    end

endmodule
